@@ rtl/core/slt_pkg.sv @@
// shared types, constants and decode functions for the source token lexer
// used by slt_lexer, slt_res_fifo and source_token_lexer_core; no dependencies
package slt_pkg;

    // sizing
    localparam int POS_BITS      = 32;
    localparam int LEN_BITS      = 16;
    localparam int KEYWORD_CHARS = 6;
    localparam int KW_BITS       = 8 * KEYWORD_CHARS;
    localparam int FIFO_DEPTH    = 4;
    localparam int PTR_BITS      = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS      = $clog2(FIFO_DEPTH + 1);

    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    typedef logic [POS_BITS-1:0] pos_t;
    typedef logic [LEN_BITS-1:0] len_t;
    typedef logic [KW_BITS-1:0]  prefix_t;

    // scanner modes
    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_OP,
        MODE_AMP,
        MODE_BAR,
        MODE_LINE,
        MODE_BLOCK,
        MODE_BSTAR,
        MODE_STR,
        MODE_CH1,
        MODE_CH2,
        MODE_CHE1,
        MODE_CHE2,
        MODE_NUM,
        MODE_WORD
    } mode_t;

    // token kinds
    localparam logic [5:0] KIND_COLON     = 6'd0;
    localparam logic [5:0] KIND_SEMI      = 6'd1;
    localparam logic [5:0] KIND_LPAREN    = 6'd2;
    localparam logic [5:0] KIND_RPAREN    = 6'd3;
    localparam logic [5:0] KIND_LBRACKET  = 6'd4;
    localparam logic [5:0] KIND_RBRACKET  = 6'd5;
    localparam logic [5:0] KIND_LBRACE    = 6'd6;
    localparam logic [5:0] KIND_RBRACE    = 6'd7;
    localparam logic [5:0] KIND_TILDE     = 6'd8;
    localparam logic [5:0] KIND_PLUS_EQ   = 6'd9;
    localparam logic [5:0] KIND_PLUS      = 6'd10;
    localparam logic [5:0] KIND_MINUS_EQ  = 6'd11;
    localparam logic [5:0] KIND_MINUS     = 6'd12;
    localparam logic [5:0] KIND_STAR_EQ   = 6'd13;
    localparam logic [5:0] KIND_STAR      = 6'd14;
    localparam logic [5:0] KIND_PCT_EQ    = 6'd15;
    localparam logic [5:0] KIND_PCT       = 6'd16;
    localparam logic [5:0] KIND_EQ_EQ     = 6'd17;
    localparam logic [5:0] KIND_ASSIGN    = 6'd18;
    localparam logic [5:0] KIND_SLASH_EQ  = 6'd19;
    localparam logic [5:0] KIND_SLASH     = 6'd20;
    localparam logic [5:0] KIND_AND_AND   = 6'd21;
    localparam logic [5:0] KIND_OR_OR     = 6'd22;
    localparam logic [5:0] KIND_BACKSLASH = 6'd23;
    localparam logic [5:0] KIND_COMMA     = 6'd24;
    localparam logic [5:0] KIND_DOT       = 6'd25;
    localparam logic [5:0] KIND_GT        = 6'd26;
    localparam logic [5:0] KIND_LT        = 6'd27;
    localparam logic [5:0] KIND_EOF       = 6'd28;
    localparam logic [5:0] KIND_STRING    = 6'd29;
    localparam logic [5:0] KIND_CHAR     = 6'd30;
    localparam logic [5:0] KIND_FLOAT     = 6'd31;
    localparam logic [5:0] KIND_INT       = 6'd32;
    localparam logic [5:0] KIND_KW_INT    = 6'd33;
    localparam logic [5:0] KIND_KW_MAIN   = 6'd34;
    localparam logic [5:0] KIND_KW_CHAR   = 6'd35;
    localparam logic [5:0] KIND_KW_BOOL   = 6'd36;
    localparam logic [5:0] KIND_KW_FLOAT  = 6'd37;
    localparam logic [5:0] KIND_KW_STRING = 6'd38;
    localparam logic [5:0] KIND_KW_FOR    = 6'd39;
    localparam logic [5:0] KIND_KW_WHILE  = 6'd40;
    localparam logic [5:0] KIND_KW_FUNC   = 6'd41;
    localparam logic [5:0] KIND_BOOL_LIT  = 6'd42;
    localparam logic [5:0] KIND_IDENT     = 6'd43;

    // input item codes
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    // ascii codes
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_PCT     = 8'h25;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_0       = 8'd48;
    localparam logic [7:0] CH_9       = 8'd57;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_Z = 8'd90;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LOWER_A = 8'd97;
    localparam logic [7:0] CH_LOWER_Z = 8'd122;
    localparam logic [7:0] CH_B       = 8'h62;
    localparam logic [7:0] CH_N       = 8'h6E;
    localparam logic [7:0] CH_R       = 8'h72;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_BAR     = 8'h7C;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_TILDE   = 8'h7E;

    // decoded escape values
    localparam logic [7:0] ESC_NL   = 8'd10;
    localparam logic [7:0] ESC_TAB  = 8'd9;
    localparam logic [7:0] ESC_BS   = 8'd8;
    localparam logic [7:0] ESC_CR   = 8'd13;
    localparam logic [7:0] ESC_BSL  = 8'd92;
    localparam logic [7:0] ESC_NONE = 8'd0;

    // keywords, packed right-justified like the word prefix
    localparam prefix_t KW_INT    = "int";
    localparam prefix_t KW_MAIN   = "main";
    localparam prefix_t KW_CHAR   = "char";
    localparam prefix_t KW_BOOL   = "bool";
    localparam prefix_t KW_FLOAT  = "float";
    localparam prefix_t KW_STRING = "string";
    localparam prefix_t KW_FOR    = "for";
    localparam prefix_t KW_WHILE  = "while";
    localparam prefix_t KW_FUNC   = "func";
    localparam prefix_t KW_VOID   = "void";
    localparam prefix_t KW_TRUE_L = "true";
    localparam prefix_t KW_TRUE_U = "TRUE";
    localparam prefix_t KW_FALS_L = "false";
    localparam prefix_t KW_FALS_U = "FALSE";

    // one result record
    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] start_pos;
        logic [15:0] length;
        logic [7:0]  value;
        logic        last;
    } res_t;

    // up to two results of one item, toward the result queue
    typedef struct packed {
        logic valid0;
        res_t res0;
        logic valid1;
        res_t res1;
    } res_pair_t;

    typedef struct packed {
        logic       hit;
        logic [5:0] kind;
        logic [7:0] value;
    } kw_t;

    // what a byte does when lexed from idle
    typedef struct packed {
        logic       emit;
        logic [5:0] kind;
        mode_t      mode;
        logic       starts;
        logic       set_held;
        logic       set_prefix;
        logic       clr_dot;
    } idle_t;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[CH_0:CH_9]};
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return c inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]};
    endfunction

    function automatic res_t mk_res(input logic [5:0] k, input pos_t s, input len_t l,
                                    input logic [7:0] v);
        res_t r;
        r.kind      = k;
        r.start_pos = 32'(s);
        r.length    = 16'(l);
        r.value     = v;
        r.last      = 1'b0;
        return r;
    endfunction

    // kind of a one-or-two character operator from its first byte
    function automatic logic [5:0] op_kind(input logic [7:0] held, input logic with_eq);
        logic [5:0] k;
        case (held)
            CH_PLUS:  k = with_eq ? KIND_PLUS_EQ  : KIND_PLUS;
            CH_MINUS: k = with_eq ? KIND_MINUS_EQ : KIND_MINUS;
            CH_STAR:  k = with_eq ? KIND_STAR_EQ  : KIND_STAR;
            CH_PCT:   k = with_eq ? KIND_PCT_EQ   : KIND_PCT;
            CH_EQ:    k = with_eq ? KIND_EQ_EQ    : KIND_ASSIGN;
            default:  k = with_eq ? KIND_SLASH_EQ : KIND_SLASH;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] esc_value(input logic [7:0] c);
        logic [7:0] v;
        case (c)
            CH_N:      v = ESC_NL;
            CH_T:      v = ESC_TAB;
            CH_B:      v = ESC_BS;
            CH_R:      v = ESC_CR;
            CH_BSLASH: v = ESC_BSL;
            default:   v = ESC_NONE;
        endcase
        return v;
    endfunction

    function automatic kw_t kw_match(input prefix_t p);
        kw_t k;
        k.hit   = 1'b1;
        k.value = 8'd0;
        case (p)
            KW_INT:    k.kind = KIND_KW_INT;
            KW_MAIN:   k.kind = KIND_KW_MAIN;
            KW_CHAR:   k.kind = KIND_KW_CHAR;
            KW_BOOL:   k.kind = KIND_KW_BOOL;
            KW_FLOAT:  k.kind = KIND_KW_FLOAT;
            KW_STRING: k.kind = KIND_KW_STRING;
            KW_FOR:    k.kind = KIND_KW_FOR;
            KW_WHILE:  k.kind = KIND_KW_WHILE;
            KW_FUNC:   k.kind = KIND_KW_FUNC;
            KW_VOID:   k.kind = KIND_KW_FUNC;
            KW_TRUE_L, KW_TRUE_U:
            begin
                k.kind  = KIND_BOOL_LIT;
                k.value = 8'd1;
            end
            KW_FALS_L, KW_FALS_U:
                k.kind = KIND_BOOL_LIT;
            default:
            begin
                k.hit  = 1'b0;
                k.kind = KIND_IDENT;
            end
        endcase
        return k;
    endfunction

    // decode of a byte seen with no token pending
    function automatic idle_t idle_lex(input logic [7:0] c);
        idle_t r;
        r.emit       = 1'b1;
        r.kind       = KIND_COLON;
        r.mode       = MODE_IDLE;
        r.starts     = 1'b0;
        r.set_held   = 1'b0;
        r.set_prefix = 1'b0;
        r.clr_dot    = 1'b0;
        case (c)
            CH_COLON:  r.kind = KIND_COLON;
            CH_SEMI:   r.kind = KIND_SEMI;
            CH_LPAREN: r.kind = KIND_LPAREN;
            CH_RPAREN: r.kind = KIND_RPAREN;
            CH_LBRACK: r.kind = KIND_LBRACKET;
            CH_RBRACK: r.kind = KIND_RBRACKET;
            CH_LBRACE: r.kind = KIND_LBRACE;
            CH_RBRACE: r.kind = KIND_RBRACE;
            CH_TILDE:  r.kind = KIND_TILDE;
            CH_BSLASH: r.kind = KIND_BACKSLASH;
            CH_COMMA:  r.kind = KIND_COMMA;
            CH_DOT:    r.kind = KIND_DOT;
            CH_GT:     r.kind = KIND_GT;
            CH_LT:     r.kind = KIND_LT;
            CH_PLUS, CH_MINUS, CH_STAR, CH_PCT, CH_EQ, CH_SLASH:
            begin
                r.emit     = 1'b0;
                r.mode     = MODE_OP;
                r.starts   = 1'b1;
                r.set_held = 1'b1;
            end
            CH_AMP:
            begin
                r.emit   = 1'b0;
                r.mode   = MODE_AMP;
                r.starts = 1'b1;
            end
            CH_BAR:
            begin
                r.emit   = 1'b0;
                r.mode   = MODE_BAR;
                r.starts = 1'b1;
            end
            CH_SQUOTE:
            begin
                r.emit   = 1'b0;
                r.mode   = MODE_CH1;
                r.starts = 1'b1;
            end
            CH_DQUOTE:
            begin
                r.emit   = 1'b0;
                r.mode   = MODE_STR;
                r.starts = 1'b1;
            end
            default:
            begin
                r.emit = 1'b0;
                if (is_letter(c))
                begin
                    r.mode       = MODE_WORD;
                    r.starts     = 1'b1;
                    r.set_prefix = 1'b1;
                end
                else if (is_digit(c))
                begin
                    r.mode    = MODE_NUM;
                    r.starts  = 1'b1;
                    r.clr_dot = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/source_token_lexer_core.sv @@
// top level of the streaming source token lexer
// depends on slt_pkg, slt_lexer and slt_res_fifo
//
// Streaming lexer: one source byte (func = 0) or an end marker (func = 1) per
// input transfer, token records out, one record per output transfer. An input
// item is taken every cycle while the four-entry result queue holds at most two
// records; the item is held in the input register, then its records are written
// to the result queue and offered on the output from there. A byte that closes
// one token and opens a punctuation token, and every end marker that flushes a
// token, yields two records, which leave in separate output transfers; sustained
// rate is one item per cycle otherwise, while the output is not stalled.
// Positions count bytes from reset or from the last end marker; last marks
// the final record caused by an item.
module source_token_lexer_core
    import slt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [7:0]  char_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  kind,
    output logic [31:0] start_pos,
    output logic [15:0] length,
    output logic [7:0]  value,
    output logic        last
);

    logic       valid_reg, valid_next;
    logic       func_reg;
    logic [7:0] char_reg;
    logic       room;
    logic       step;
    logic       accept;
    res_pair_t  pair;
    res_t       head;

    // input register handshake
    assign step       = valid_reg && room;
    assign in_stall   = valid_reg && !room;
    assign accept     = in_valid && !in_stall;
    assign valid_next = accept ? 1'b1 : (step ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            char_reg <= char_in;
        end
    end

    // lexing step
    slt_lexer u_lexer (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .func    (func_reg),
        .char_in (char_reg),
        .res     (pair)
    );

    // result queue
    slt_res_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .push_data (pair),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (head)
    );

    assign kind      = head.kind;
    assign start_pos = head.start_pos;
    assign length    = head.length;
    assign value     = head.value;
    assign last      = head.last;

endmodule

@@ rtl/core/slt_lexer.sv @@
// scanner state registers and the one-step lexing logic for one item
// depends on slt_pkg
module slt_lexer
    import slt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  logic      func,
    input  logic [7:0] char_in,
    output res_pair_t res
);

    mode_t      mode_reg, mode_next;
    pos_t       pos_reg, pos_next;
    pos_t       start_reg, start_next;
    len_t       len_reg, len_next;
    prefix_t    prefix_reg, prefix_next;
    logic [7:0] held_reg, held_next;
    logic       dot_reg, dot_next;

    idle_t      idl;
    kw_t        kw;
    len_t       len_inc;
    res_t       word_res;
    res_t       num_res;
    logic       pend_v;
    res_t       pend;
    logic       tail_v;
    res_t       tail;
    logic       use_idle;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            start_reg  <= '0;
            len_reg    <= '0;
            prefix_reg <= '0;
            held_reg   <= '0;
            dot_reg    <= 1'b0;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            len_reg    <= len_next;
            prefix_reg <= prefix_next;
            held_reg   <= held_next;
            dot_reg    <= dot_next;
        end
    end

    // helpers shared by several modes
    always_comb
    begin
        idl      = idle_lex(char_in);
        kw       = kw_match(prefix_reg);
        len_inc  = (len_reg == LEN_MAX) ? len_reg : len_reg + 1'b1;
        num_res  = mk_res(dot_reg ? KIND_FLOAT : KIND_INT, start_reg, len_reg, 8'd0);
        if ((len_reg <= LEN_BITS'(KEYWORD_CHARS)) && kw.hit)
            word_res = mk_res(kw.kind, start_reg, len_reg, kw.value);
        else
            word_res = mk_res(KIND_IDENT, start_reg, len_reg, 8'd0);
    end

    // next state and results of one item
    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        prefix_next = prefix_reg;
        held_next   = held_reg;
        dot_next    = dot_reg;
        pend_v      = 1'b0;
        pend        = '0;
        tail_v      = 1'b0;
        tail        = '0;
        use_idle    = 1'b0;

        if (func == FUNC_END)
        begin
            // flush a pending operator, string, escaped char, number or word, then end-of-file and back to reset
            case (mode_reg)
                MODE_OP:
                begin
                    pend_v = 1'b1;
                    pend   = mk_res(op_kind(held_reg, 1'b0), start_reg, len_t'(1), 8'd0);
                end
                MODE_STR:
                begin
                    pend_v = 1'b1;
                    pend   = mk_res(KIND_STRING, start_reg, len_reg, 8'd0);
                end
                MODE_CHE2:
                begin
                    pend_v = (held_reg != ESC_NONE);
                    pend   = mk_res(KIND_CHAR, start_reg, len_t'(3), held_reg);
                end
                MODE_NUM:
                begin
                    pend_v = 1'b1;
                    pend   = num_res;
                end
                MODE_WORD:
                begin
                    pend_v = 1'b1;
                    pend   = word_res;
                end
                default:
                    pend_v = 1'b0;
            endcase
            tail_v      = 1'b1;
            tail        = mk_res(KIND_EOF, pos_reg, len_t'(0), 8'd0);
            mode_next   = MODE_IDLE;
            pos_next    = '0;
            start_next  = '0;
            len_next    = '0;
            prefix_next = '0;
            held_next   = '0;
            dot_next    = 1'b0;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
            case (mode_reg)
                MODE_OP:
                begin
                    if ((held_reg == CH_SLASH) && (char_in == CH_SLASH))
                        mode_next = MODE_LINE;
                    else if ((held_reg == CH_SLASH) && (char_in == CH_STAR))
                        mode_next = MODE_BSTAR;
                    else if (char_in == CH_EQ)
                    begin
                        pend_v    = 1'b1;
                        pend      = mk_res(op_kind(held_reg, 1'b1), start_reg, len_t'(2), 8'd0);
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        pend_v   = 1'b1;
                        pend     = mk_res(op_kind(held_reg, 1'b0), start_reg, len_t'(1), 8'd0);
                        use_idle = 1'b1;
                    end
                end
                MODE_AMP, MODE_BAR:
                begin
                    if ((mode_reg == MODE_AMP) && (char_in == CH_AMP))
                    begin
                        pend_v    = 1'b1;
                        pend      = mk_res(KIND_AND_AND, start_reg, len_t'(2), 8'd0);
                        mode_next = MODE_IDLE;
                    end
                    else if ((mode_reg == MODE_BAR) && (char_in == CH_BAR))
                    begin
                        pend_v    = 1'b1;
                        pend      = mk_res(KIND_OR_OR, start_reg, len_t'(2), 8'd0);
                        mode_next = MODE_IDLE;
                    end
                    else
                        use_idle = 1'b1;
                end
                MODE_LINE:
                begin
                    if (char_in == CH_NL)
                        mode_next = MODE_IDLE;
                end
                MODE_BLOCK:
                begin
                    if (char_in == CH_STAR)
                        mode_next = MODE_BSTAR;
                end
                MODE_BSTAR:
                begin
                    if (char_in == CH_SLASH)
                        mode_next = MODE_IDLE;
                    else if (char_in != CH_STAR)
                        mode_next = MODE_BLOCK;
                end
                MODE_STR:
                begin
                    len_next = len_inc;
                    if (char_in == CH_DQUOTE)
                    begin
                        pend_v    = 1'b1;
                        pend      = mk_res(KIND_STRING, start_reg, len_inc, 8'd0);
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_CH1:
                begin
                    if (char_in == CH_BSLASH)
                        mode_next = MODE_CHE1;
                    else
                    begin
                        held_next = char_in;
                        mode_next = MODE_CH2;
                    end
                end
                MODE_CH2:
                begin
                    pend_v    = (held_reg != CH_SQUOTE) && (char_in == CH_SQUOTE);
                    pend      = mk_res(KIND_CHAR, start_reg, len_t'(3), held_reg);
                    mode_next = MODE_IDLE;
                end
                MODE_CHE1:
                begin
                    held_next = esc_value(char_in);
                    mode_next = MODE_CHE2;
                end
                MODE_CHE2:
                begin
                    pend_v    = (held_reg != ESC_NONE);
                    pend      = mk_res(KIND_CHAR, start_reg, len_t'(4), held_reg);
                    mode_next = MODE_IDLE;
                end
                MODE_NUM:
                begin
                    if (is_digit(char_in))
                        len_next = len_inc;
                    else if ((char_in == CH_DOT) && !dot_reg)
                    begin
                        len_next = len_inc;
                        dot_next = 1'b1;
                    end
                    else
                    begin
                        pend_v   = 1'b1;
                        pend     = num_res;
                        use_idle = 1'b1;
                    end
                end
                MODE_WORD:
                begin
                    if (is_digit(char_in) || is_letter(char_in) || (char_in == CH_UNDER))
                    begin
                        len_next = len_inc;
                        if (len_inc <= LEN_BITS'(KEYWORD_CHARS))
                            prefix_next = {prefix_reg[KW_BITS-9:0], char_in};
                    end
                    else
                    begin
                        pend_v   = 1'b1;
                        pend     = word_res;
                        use_idle = 1'b1;
                    end
                end
                default:
                    use_idle = 1'b1;
            endcase

            // relex the byte from idle
            if (use_idle)
            begin
                mode_next = idl.mode;
                tail_v    = idl.emit;
                tail      = mk_res(idl.kind, pos_reg, len_t'(1), 8'd0);
                if (idl.starts)
                begin
                    start_next = pos_reg;
                    len_next   = len_t'(1);
                end
                if (idl.set_held)
                    held_next = char_in;
                if (idl.set_prefix)
                    prefix_next = prefix_t'(char_in);
                if (idl.clr_dot)
                    dot_next = 1'b0;
            end
        end
    end

    // pack results in order, marking the final one
    always_comb
    begin
        res = '0;
        if (pend_v)
        begin
            res.valid0    = 1'b1;
            res.res0      = pend;
            res.res0.last = !tail_v;
            res.valid1    = tail_v;
            res.res1      = tail;
            res.res1.last = 1'b1;
        end
        else
        begin
            res.valid0    = tail_v;
            res.res0      = tail;
            res.res0.last = 1'b1;
        end
    end

endmodule

@@ rtl/core/slt_res_fifo.sv @@
// result queue: takes up to two results a cycle, delivers one per transfer
// depends on slt_pkg
module slt_res_fifo
    import slt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  res_pair_t push_data,
    output logic      room,
    output logic      out_valid,
    input  logic      out_stall,
    output res_t      out_data
);

    res_t                mem [FIFO_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                wr0, wr1, pop;
    logic [PTR_BITS-1:0] wr_ptr_p1;

    // room for a full pair, counted without the pop of this cycle
    assign room      = (count_reg <= CNT_BITS'(FIFO_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr0         = push && push_data.valid0;
        wr1         = push && push_data.valid0 && push_data.valid1;
        pop         = out_valid && !out_stall;
        wr_ptr_p1   = wr_ptr_reg + 1'b1;
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(wr0) + PTR_BITS'(wr1);
        rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
        count_next  = count_reg + CNT_BITS'(wr0) + CNT_BITS'(wr1) - CNT_BITS'(pop);
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr0)
            mem[wr_ptr_reg] <= push_data.res0;
        if (wr1)
            mem[wr_ptr_p1] <= push_data.res1;
    end

endmodule
